// File: rtl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on clk_i, disabled while rst_ni is low.
`define JNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the same check.
`define JNC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication form.
`define JNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jnc_pkg.sv
package jnc_pkg;

  localparam logic [7:0] ChOpenBrace    = 8'h7B;
  localparam logic [7:0] ChOpenBracket  = 8'h5B;
  localparam logic [7:0] ChCloseBrace   = 8'h7D;
  localparam logic [7:0] ChCloseBracket = 8'h5D;
  localparam logic [7:0] ChBackslash    = 8'h5C;
  localparam logic [7:0] ChQuote        = 8'h22;

  typedef enum logic {
    KIND_BRACE   = 1'b0,
    KIND_BRACKET = 1'b1
  } closer_kind_e;

  typedef logic [7:0] char_t;

endpackage

// File: rtl/json_nesting_closer_top.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i / in_ready_o | symbol_i, final_char_i
// output  | out       | out_valid_o / out_ready_i | closer_o, nothing_to_add_o,
//         |           |                        | depth_overflow_o, run_end_o
//
// A character that is not the last one is accepted and gives no result.
// After the last character is accepted, the sequencer drains the closer stack
// one result per cycle while the output slot is free: a quote if a string is
// open, then N closers (N = stack entries), or one "nothing to add" result.
// Reset clears the flags and the stack count; the stack bits need no clearing.
// A stalled output transaction holds the sequencer in its drain step.
`include "assert_macros.svh"

module json_nesting_closer_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jnc_pkg::char_t    symbol_i,
  input  logic              final_char_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jnc_pkg::char_t    closer_o,
  output logic              nothing_to_add_o,
  output logic              depth_overflow_o,
  output logic              run_end_o
);
  import jnc_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic            state_q, state_d;
  logic            esc_q, esc_d;
  logic            str_q, str_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [STACK_DEPTH-1:0] stack_q;

  logic            out_valid_q, out_valid_d;
  char_t           closer_q, closer_d;
  logic            none_q, none_d;
  logic            dovf_q, dovf_d;
  logic            last_q, last_d;

  logic            in_acc;
  logic            slot_free;
  logic            push_en;
  closer_kind_e    push_kind;
  logic [IdxW-1:0] top_idx;
  closer_kind_e    top_kind;
  logic            res_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign top_idx    = IdxW'(cnt_q - OneCnt);
  assign top_kind   = closer_kind_e'(stack_q[top_idx]);

  always_comb begin
    state_d     = state_q;
    esc_d       = esc_q;
    str_d       = str_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    push_en     = 1'b0;
    push_kind   = KIND_BRACE;
    res_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    closer_d    = closer_q;
    none_d      = none_q;
    dovf_d      = dovf_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (symbol_i == ChBackslash) begin
            esc_d = 1'b1;
          end else if (symbol_i == ChQuote) begin
            str_d = ~str_q;
          end else if (!str_q) begin
            if (symbol_i == ChOpenBrace || symbol_i == ChOpenBracket) begin
              push_kind = (symbol_i == ChOpenBracket) ? KIND_BRACKET : KIND_BRACE;
              if (cnt_q >= DepthCnt) begin
                ovf_d = 1'b1;
              end else begin
                push_en = 1'b1;
                cnt_d   = cnt_q + OneCnt;
              end
            end else if (symbol_i == ChCloseBrace || symbol_i == ChCloseBracket) begin
              if (cnt_q != '0 &&
                  top_kind == ((symbol_i == ChCloseBracket) ? KIND_BRACKET : KIND_BRACE)) begin
                cnt_d = cnt_q - OneCnt;
              end
            end
          end
          if (final_char_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          res_load    = 1'b1;
          out_valid_d = 1'b1;
          dovf_d      = ovf_q;
          if (str_q) begin
            closer_d = ChQuote;
            none_d   = 1'b0;
            last_d   = (cnt_q == '0);
            str_d    = 1'b0;
          end else if (cnt_q != '0) begin
            closer_d = (top_kind == KIND_BRACKET) ? ChCloseBracket : ChCloseBrace;
            none_d   = 1'b0;
            last_d   = (cnt_q == OneCnt);
            cnt_d    = cnt_q - OneCnt;
          end else begin
            closer_d = '0;
            none_d   = 1'b1;
            last_d   = 1'b1;
          end
          if (last_d) begin
            state_d = S_IDLE;
            esc_d   = 1'b0;
            str_d   = 1'b0;
            ovf_d   = 1'b0;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      esc_q       <= 1'b0;
      str_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      esc_q       <= esc_d;
      str_q       <= str_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_q[cnt_q[IdxW-1:0]] <= push_kind;
    end
    closer_q <= closer_d;
    none_q   <= none_d;
    dovf_q   <= dovf_d;
    last_q   <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign closer_o         = closer_q;
  assign nothing_to_add_o = none_q;
  assign depth_overflow_o = dovf_q;
  assign run_end_o        = last_q;

  `JNC_ASSERT(cnt_in_range_a, cnt_q <= DepthCnt, "Stack count exceeds the stack depth.")
  `JNC_ASSERT_IMPL(none_is_last_a, out_valid_o && nothing_to_add_o, run_end_o,
                   "A nothing-to-add result is not marked as the run end.")
  `JNC_ASSERT_NEXT(end_clears_a, res_load && last_d,
                   state_q == S_IDLE && cnt_q == '0 && !str_q && !ovf_q,
                   "State is not cleared after the last result of a run.")
  `JNC_ASSERT_IMPL(busy_not_ready_a, state_q == S_EMIT, !in_ready_o,
                   "Input is ready while the stack is draining.")

endmodule

// File: bench/json_nesting_closer_top_tb.sv
module json_nesting_closer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jnc_pkg::*;

  localparam int StackDepth = 32;
  localparam int LevelBits = $clog2(StackDepth + 1);
  localparam char_t Specials [6] = '{ChOpenBrace, ChOpenBracket, ChCloseBrace,
                                     ChCloseBracket, ChBackslash, ChQuote};

  typedef struct {
    char_t closer;
    logic  none;
    logic  overflow;
    logic  last;
  } closer_result_t;

  class closer_scoreboard;
    bit                   escape_pending;
    bit                   str_open;
    bit                   overflow_seen;
    logic [LevelBits-1:0] level;
    closer_kind_e         kinds [StackDepth];
    closer_result_t       expected_closers [$];
    int                   errors;

    function new();
      escape_pending = 0;
      str_open       = 0;
      overflow_seen  = 0;
      level          = '0;
      errors         = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    function void add_closer(char_t ch, logic none, logic last);
      closer_result_t r;
      r.closer   = ch;
      r.none     = none;
      r.overflow = overflow_seen;
      r.last     = last;
      expected_closers.push_back(r);
    endfunction

    function void push_kind(closer_kind_e kind);
      if (level >= StackDepth) begin
        overflow_seen = 1;
      end else begin
        kinds[level] = kind;
        level++;
      end
    endfunction

    function void note_input(char_t sym, logic fin);
      closer_kind_e kind;
      int           emitted;
      emitted = 0;
      if (escape_pending) begin
        escape_pending = 0;
      end else if (sym == ChBackslash) begin
        escape_pending = 1;
      end else if (sym == ChQuote) begin
        str_open = !str_open;
      end else if (!str_open) begin
        if (sym == ChOpenBrace) begin
          push_kind(KIND_BRACE);
        end else if (sym == ChOpenBracket) begin
          push_kind(KIND_BRACKET);
        end else if (sym == ChCloseBrace || sym == ChCloseBracket) begin
          kind = (sym == ChCloseBracket) ? KIND_BRACKET : KIND_BRACE;
          if (level != 0 && kinds[level-1] == kind) level--;
        end
      end
      if (!fin) return;
      if (str_open) begin
        add_closer(ChQuote, 1'b0, level == 0);
        emitted++;
      end
      while (level != 0) begin
        level--;
        add_closer((kinds[level] == KIND_BRACKET) ? ChCloseBracket : ChCloseBrace,
                   1'b0, level == 0);
        emitted++;
      end
      if (emitted == 0) add_closer(8'h00, 1'b1, 1'b1);
      escape_pending = 0;
      str_open       = 0;
      overflow_seen  = 0;
    endfunction

    task check_result(char_t closer, logic none, logic overflow, logic last);
      closer_result_t exp;
      if (expected_closers.size() == 0) begin
        report_mismatch($sformatf("unexpected result closer=%h none=%b", closer, none));
        return;
      end
      exp = expected_closers.pop_front();
      if (!exp.none && closer !== exp.closer)
        report_mismatch($sformatf("closer %h, expected %h", closer, exp.closer));
      if (none !== exp.none)
        report_mismatch($sformatf("nothing_to_add %b, expected %b", none, exp.none));
      if (overflow !== exp.overflow)
        report_mismatch($sformatf("depth_overflow %b, expected %b", overflow,
                                  exp.overflow));
      if (last !== exp.last)
        report_mismatch($sformatf("run_end %b, expected %b", last, exp.last));
    endtask
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  char_t symbol_i = 8'h00;
  logic  final_char_i = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  char_t closer_o;
  logic  nothing_to_add_o;
  logic  depth_overflow_o;
  logic  run_end_o;

  logic  hold_rx = 1'b0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  int    chars_sent = 0;

  closer_scoreboard sb;
  char_t            text [$];

  json_nesting_closer_top #(
    .STACK_DEPTH(StackDepth)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .symbol_i        (symbol_i),
    .final_char_i    (final_char_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .closer_o        (closer_o),
    .nothing_to_add_o(nothing_to_add_o),
    .depth_overflow_o(depth_overflow_o),
    .run_end_o       (run_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(closer_o, nothing_to_add_o, depth_overflow_o, run_end_o);
    out_ready_i <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic hold_receiver(int cycles);
    hold_rx <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  endtask

  task automatic send_char(char_t sym, logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    symbol_i     <= sym;
    final_char_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(sym, fin);
    chars_sent++;
  endtask

  task automatic send_text(ref char_t chars [$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic build_text(ref char_t chars [$]);
    int           mode;
    int           len;
    closer_kind_e shadow [$];
    closer_kind_e kind;
    int           pick;
    chars.delete();
    mode = $urandom_range(99);
    if (mode < 12) begin
      repeat ($urandom_range(40, 26))
        chars.push_back($urandom_range(1) ? ChOpenBracket : ChOpenBrace);
      if ($urandom_range(1)) chars.push_back(ChQuote);
      chars.push_back(char_t'($urandom_range(8'h39, 8'h30)));
    end else if (mode < 30) begin
      repeat ($urandom_range(16, 1))
        chars.push_back(($urandom_range(3) == 0) ? Specials[$urandom_range(5)]
                                                 : char_t'($urandom_range(255)));
    end else begin
      len = $urandom_range(($urandom_range(3) == 0) ? 6 : 28, 1);
      while (chars.size() < len) begin
        pick = $urandom_range(99);
        if (pick < 28) begin
          kind = closer_kind_e'($urandom_range(1));
          shadow.push_back(kind);
          chars.push_back((kind == KIND_BRACKET) ? ChOpenBracket : ChOpenBrace);
        end else if (pick < 50) begin
          if (shadow.size() > 0 && $urandom_range(9) != 0) begin
            kind = shadow.pop_back();
            chars.push_back((kind == KIND_BRACKET) ? ChCloseBracket : ChCloseBrace);
          end else begin
            chars.push_back($urandom_range(1) ? ChCloseBracket : ChCloseBrace);
          end
        end else if (pick < 72) begin
          chars.push_back(ChQuote);
          repeat ($urandom_range(4)) begin
            if ($urandom_range(4) == 0) begin
              chars.push_back(ChBackslash);
              chars.push_back($urandom_range(1) ? ChQuote : char_t'($urandom_range(255)));
            end else begin
              chars.push_back(char_t'($urandom_range(126, 32)));
            end
          end
          if ($urandom_range(4) != 0) chars.push_back(ChQuote);
        end else begin
          chars.push_back($urandom_range(2) == 0 ? 8'h3A : char_t'($urandom_range(8'h39, 8'h2C)));
        end
      end
    end
  endtask

  task automatic run_random(int char_goal);
    while (chars_sent < char_goal) begin
      build_text(text);
      send_text(text);
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text = '{8'h00};                                   send_text(text);
    text = '{8'hFF};                                   send_text(text);
    text = '{ChOpenBrace};                             send_text(text);
    text = '{ChOpenBracket, ChOpenBrace};              send_text(text);
    text = '{ChQuote};                                 send_text(text);
    text = '{ChOpenBracket, ChQuote, 8'h61, ChBackslash};
    send_text(text);
    text = '{ChCloseBrace};                            send_text(text);
    text = '{ChOpenBrace, ChCloseBracket, ChCloseBrace};
    send_text(text);
    text = '{ChBackslash, ChQuote, ChOpenBracket};     send_text(text);
    text = '{ChQuote, ChOpenBrace, ChQuote, ChOpenBracket, ChCloseBracket};
    send_text(text);

    run_random(100);

    // The receiver stays blocked while a deep, overflowing text with an open
    // string arrives, so the drain stalls and the input backs up behind it.
    fork
      hold_receiver(300);
    join_none
    text.delete();
    repeat (StackDepth + 2) text.push_back($urandom_range(1) ? ChOpenBracket : ChOpenBrace);
    text.push_back(ChQuote);
    text.push_back(8'h78);
    send_text(text);
    run_random(chars_sent + 20);

    tx_idle_pct = 87;
    run_random(220);
    tx_idle_pct  = 0;
    rx_stall_pct = 87;
    run_random(330);
    tx_idle_pct  = 7;
    rx_stall_pct = 7;
    run_random(460);
    in_valid_i <= 1'b0;

    while (sb.expected_closers.size() != 0) @(posedge clk_i);
    repeat (StackDepth + 8) @(posedge clk_i);
    if (sb.expected_closers.size() != 0)
      sb.report_mismatch("results still expected at the end");

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
